FILE: rtl/tape_speed_slew_controller_core_defines.svh
// ----------------------------------------------------------------------------
// tape speed slew controller core: assertion macros
// shared property templates, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef TAPE_SPEED_SLEW_CONTROLLER_CORE_DEFINES_SVH
`define TAPE_SPEED_SLEW_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define TSSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tssc_pkg.sv
// ----------------------------------------------------------------------------
// tssc_pkg
// types, codes and constants of the tape speed slew controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tssc_pkg;

  // samples per block and sample counter width
  localparam int BLOCK = 32;
  localparam int CNT_W = (BLOCK > 1) ? $clog2(BLOCK) : 1;

  localparam int SPEED_W = 23;
  localparam int MAX_W   = 22;
  localparam int COEF_W  = 21;

  localparam logic [COEF_W-1:0]  ONE_Q20     = 21'd1048576;
  localparam logic [COEF_W-1:0]  NUDGE_LIMIT = 21'd10486;
  localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(BLOCK - 1);

  // input op codes
  localparam logic [2:0] OP_SET_ACTIVE = 3'd0;
  localparam logic [2:0] OP_INACTIVE   = 3'd1;
  localparam logic [2:0] OP_ACTIVE     = 3'd2;
  localparam logic [2:0] OP_NUDGE      = 3'd3;
  localparam logic [2:0] OP_SET_LOCK   = 3'd4;
  localparam logic [2:0] OP_RUN_BLOCK  = 3'd5;

  // slew modes
  localparam logic [1:0] SLEW_STANDARD = 2'd0;
  localparam logic [1:0] SLEW_JUMP     = 2'd2;

  // lock codes, two's complement; minus two is never stored
  localparam logic [1:0] LOCK_NONE = 2'b00;
  localparam logic [1:0] LOCK_FWD  = 2'b01;
  localparam logic [1:0] LOCK_RSVD = 2'b10;
  localparam logic [1:0] LOCK_REV  = 2'b11;

  // configuration register indexes
  localparam logic [2:0] CFG_SPEED_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_COEF_STD     = 3'd1;
  localparam logic [2:0] CFG_COEF_FAST    = 3'd2;
  localparam logic [2:0] CFG_DECAY_STEP   = 3'd3;
  localparam logic [2:0] CFG_MOVING_FLOOR = 3'd4;

  typedef enum logic [2:0] {
    K_SET_ACTIVE,
    K_INACTIVE,
    K_ACTIVE,
    K_NUDGE,
    K_LOCK,
    K_RUN
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_ADD,
    ST_RUN
  } back_state_e;

  typedef struct packed {
    logic [MAX_W-1:0]  speed_limit;
    logic [COEF_W-1:0] coef_std;
    logic [COEF_W-1:0] coef_fast;
    logic [COEF_W-1:0] decay_step;
    logic [COEF_W-1:0] moving_floor;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic                       active_flag;
    logic [1:0]                 slew_mode;
    logic signed [SPEED_W-1:0]  value;
    logic [1:0]                 lock;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/tssc_front.sv
// ----------------------------------------------------------------------------
// tssc_front
// accepts input words, decodes them into commands and queues up to two of them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tssc_front import tssc_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [2:0]                op_i,
  input  wire logic                      active_flag_i,
  input  wire logic [1:0]                slew_mode_i,
  input  wire logic signed [SPEED_W-1:0] value_i,
  input  wire logic signed [1:0]         lock_dir_i,
  input  wire logic [MAX_W-1:0]          speed_limit_i,
  output logic                           cmd_valid_o,
  output cmd_t                           cmd_o,
  input  wire logic                      cmd_pop_i
);

  cmd_t        dec;
  logic        dec_ok;
  logic        push;
  cmd_t        mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic signed [SPEED_W:0] mx, vx;

  // decode the word, clamp the active speed against the limit
  always_comb begin
    mx  = {2'b00, speed_limit_i};
    vx  = {value_i[SPEED_W-1], value_i};
    dec = '{kind: K_SET_ACTIVE, active_flag: active_flag_i, slew_mode: slew_mode_i,
            value: value_i, lock: LOCK_NONE};
    dec_ok = 1'b1;
    unique case (op_i)
      OP_SET_ACTIVE: dec.kind = K_SET_ACTIVE;
      OP_INACTIVE:   dec.kind = K_INACTIVE;
      OP_ACTIVE: begin
        dec.kind = K_ACTIVE;
        if (vx > mx) begin
          dec.value = mx[SPEED_W-1:0];
        end else if (vx < -mx) begin
          dec.value = SPEED_W'(-mx);
        end
      end
      OP_NUDGE:      dec.kind = K_NUDGE;
      OP_SET_LOCK: begin
        dec.kind = K_LOCK;
        dec.lock = (lock_dir_i == LOCK_RSVD) ? LOCK_NONE : lock_dir_i;
      end
      OP_RUN_BLOCK:  dec.kind = K_RUN;
      default:       dec_ok = 1'b0;
    endcase
  end

  // two entry queue
  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && dec_ok;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !cmd_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tssc_back.sv
// ----------------------------------------------------------------------------
// tssc_back
// executes queued commands: settings, nudge accumulator and lowpass samples
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tape_speed_slew_controller_core_defines.svh"

module tssc_back import tssc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire logic                cmd_valid_i,
  input  wire cmd_t                cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [SPEED_W-1:0] sample_speed_o,
  output logic                     last_o,
  output logic                     moving_o
);

  back_state_e st_q, st_d;
  logic        active_q, active_d;
  logic        quick_q, quick_d;
  logic [1:0]  lock_q, lock_d;
  logic signed [SPEED_W-1:0] ta_q, ta_d, ti_q, ti_d, delta_q, delta_d;
  logic signed [SPEED_W-1:0] sum_q, sum_d, slew_q, slew_d;
  logic [COEF_W-1:0] coeff_q, coeff_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic signed [SPEED_W-1:0] sample_q, sample_d;
  logic        last_q, last_d;
  logic        step;

  // lowpass datapath
  logic signed [SPEED_W-1:0] tgt;
  logic signed [SPEED_W:0]   diff;
  logic signed [45:0]        prod, rnd;
  logic signed [25:0]        nxt;
  logic signed [SPEED_W-1:0] sat;
  logic [SPEED_W:0]          mag;

  assign tgt  = active_q ? ta_q : ti_q;
  assign diff = {tgt[SPEED_W-1], tgt} - {slew_q[SPEED_W-1], slew_q};
  assign prod = 46'(diff) * 46'($signed({1'b0, coeff_q}));
  assign rnd  = prod + 46'sd524288;
  assign nxt  = 26'(slew_q) + rnd[45:20];

  // saturate to the sample width
  always_comb begin
    if (nxt > 26'sd4194303) begin
      sat = {1'b0, {(SPEED_W-1){1'b1}}};
    end else if (nxt < -26'sd4194304) begin
      sat = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      sat = nxt[SPEED_W-1:0];
    end
  end

  assign step = (st_q == ST_RUN) && (!out_valid_q || !out_stall_i);

  // command execution and sequencing
  always_comb begin
    logic signed [SPEED_W:0]   mx, lo, hi, vx, sx;
    logic signed [SPEED_W-1:0] ntgt;
    logic signed [24:0]        mx25, s25, t25, lim25, rel25;
    mx    = {2'b00, cfg_i.speed_limit};
    mx25  = {3'b000, cfg_i.speed_limit};
    rel25 = {4'b0000, cfg_i.decay_step};
    vx    = {cmd_i.value[SPEED_W-1], cmd_i.value};
    lo    = -mx;
    hi    = mx;
    sx    = '0;
    ntgt  = '0;
    s25   = 25'(sum_q);
    t25   = '0;
    lim25 = '0;

    st_d        = st_q;
    active_d    = active_q;
    quick_d     = quick_q;
    lock_d      = lock_q;
    ta_d        = ta_q;
    ti_d        = ti_q;
    delta_d     = delta_q;
    sum_d       = sum_q;
    slew_d      = slew_q;
    coeff_d     = coeff_q;
    cnt_d       = cnt_q;
    cmd_pop_o   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    sample_d    = sample_q;
    last_d      = last_q;

    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            K_SET_ACTIVE: begin
              active_d = cmd_i.active_flag;
              quick_d  = (cmd_i.slew_mode != SLEW_STANDARD);
              ntgt     = cmd_i.active_flag ? ta_q : ti_q;
              if (cmd_i.slew_mode == SLEW_JUMP) begin
                slew_d = ntgt;
              end
              if (cmd_i.active_flag) begin
                if (lock_q == LOCK_REV && ntgt > 0) begin
                  lock_d = LOCK_NONE;
                end else if (lock_q == LOCK_FWD && ntgt < 0) begin
                  lock_d = LOCK_NONE;
                end
              end
            end
            K_INACTIVE: begin
              if (lock_q == LOCK_REV) begin
                if (vx > 0) lock_d = LOCK_NONE;
                else        lo = '0;
              end else if (lock_q == LOCK_FWD) begin
                if (vx < 0) lock_d = LOCK_NONE;
                else        hi = '0;
              end
              if (vx < lo)      ti_d = lo[SPEED_W-1:0];
              else if (vx > hi) ti_d = hi[SPEED_W-1:0];
              else              ti_d = cmd_i.value;
            end
            K_ACTIVE: ta_d = cmd_i.value;
            K_NUDGE: begin
              delta_d = cmd_i.value;
              if (lock_q == LOCK_REV && vx > 0) begin
                lock_d = LOCK_NONE;
              end else if (lock_q == LOCK_FWD && vx < 0) begin
                lock_d = LOCK_NONE;
              end
            end
            K_LOCK: lock_d = cmd_i.lock;
            K_RUN:  st_d = ST_PREP;
            default: ;
          endcase
        end
      end

      // nudge accumulator update and coefficient pick
      ST_PREP: begin
        coeff_d = quick_q ? cfg_i.coef_fast : cfg_i.coef_std;
        if (coeff_d > ONE_Q20) begin
          coeff_d = ONE_Q20;
        end
        if (delta_q != '0) begin
          lim25 = active_q ? {4'b0000, NUDGE_LIMIT} : mx25;
          t25   = s25 + 25'(delta_q);
          if (t25 > lim25)       t25 = lim25;
          else if (t25 < -lim25) t25 = -lim25;
        end else if (!sum_q[SPEED_W-1]) begin
          t25 = s25 - rel25;
          if (t25 < 0)          t25 = '0;
          else if (t25 > mx25)  t25 = mx25;
        end else begin
          t25 = s25 + rel25;
          if (t25 > 0)          t25 = '0;
          else if (t25 < -mx25) t25 = -mx25;
        end
        sum_d = t25[SPEED_W-1:0];
        st_d  = ST_ADD;
      end

      // add the accumulator and clamp against the lock
      ST_ADD: begin
        if (lock_q == LOCK_REV)      lo = '0;
        else if (lock_q == LOCK_FWD) hi = '0;
        sx = {slew_q[SPEED_W-1], slew_q} + {sum_q[SPEED_W-1], sum_q};
        if (sx < lo)      slew_d = lo[SPEED_W-1:0];
        else if (sx > hi) slew_d = hi[SPEED_W-1:0];
        else              slew_d = sx[SPEED_W-1:0];
        cnt_d = '0;
        st_d  = ST_RUN;
      end

      // one lowpass sample per cycle into the output register, while it is empty or being taken
      ST_RUN: begin
        if (step) begin
          slew_d      = sat;
          sample_d    = sat;
          last_d      = (cnt_q == CNT_LAST);
          out_valid_d = 1'b1;
          cnt_d       = cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            st_d = ST_IDLE;
          end
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      active_q    <= 1'b0;
      quick_q     <= 1'b0;
      lock_q      <= LOCK_NONE;
      ta_q        <= 23'sd1048576;
      ti_q        <= '0;
      delta_q     <= '0;
      sum_q       <= '0;
      slew_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      active_q    <= active_d;
      quick_q     <= quick_d;
      lock_q      <= lock_d;
      ta_q        <= ta_d;
      ti_q        <= ti_d;
      delta_q     <= delta_d;
      sum_q       <= sum_d;
      slew_q      <= slew_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    coeff_q  <= coeff_d;
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  // moving flag from the held sample
  assign mag            = sample_q[SPEED_W-1] ? -{1'b1, sample_q} : {1'b0, sample_q};
  assign moving_o       = (mag > {3'b000, cfg_i.moving_floor});
  assign out_valid_o    = out_valid_q;
  assign sample_speed_o = sample_q;
  assign last_o         = last_q;

  `TSSC_ASSERT_NXT(a_last_ends_run, step && (cnt_q == CNT_LAST), st_q == ST_IDLE, "block did not end after last sample")
  `TSSC_ASSERT_NXT(a_add_starts_run, st_q == ST_ADD, (st_q == ST_RUN) && (cnt_q == '0), "run did not start at sample zero")
  `TSSC_ASSERT_IMP(a_pop_only_idle, cmd_pop_o, (st_q == ST_IDLE) && cmd_valid_i, "command taken outside idle")
  `TSSC_ASSERT_IMP(a_lock_code, 1'b1, lock_q != LOCK_RSVD, "invalid lock code stored")

endmodule

`default_nettype wire

FILE: rtl/tape_speed_slew_controller_core.sv
// ----------------------------------------------------------------------------
// tape_speed_slew_controller_core
// tape transport speed controller with slew limited one-pole lowpass output
// ----------------------------------------------------------------------------
// usage
// input channel: one word per command (in_valid_i / in_stall_o). set commands
//   (ops 0 to 4) are queued and executed by the back end while idle; ops 6
//   and 7 are accepted and dropped.
// a run_block word yields BLOCK (32) output words on the output channel
//   (out_valid_o / out_stall_i), last_o marks the final one.
// sequence: the back end picks up the run word, updates the nudge accumulator,
//   clamps against the lock, then runs the lowpass loop at one sample a cycle
//   while the output register is empty or being taken.
// a two word command queue lets the input side keep accepting while the
//   back end is busy; the output register holds a sample while the receiver
//   stalls, and the lowpass loop pauses until it is taken.
// reset: settings return to their defaults, speed 0, unlocked, standard slew,
//   queue and output register empty. the user must write configuration via
//   cfg_we_i / cfg_index_i / cfg_wdata_i only while no block is in progress (unchecked).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tape_speed_slew_controller_core import tssc_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_index_i,
  input  wire logic [MAX_W-1:0]          cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [2:0]                op_i,
  input  wire logic                      active_flag_i,
  input  wire logic [1:0]                slew_mode_i,
  input  wire logic signed [SPEED_W-1:0] value_i,
  input  wire logic signed [1:0]         lock_dir_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [SPEED_W-1:0]      sample_speed_o,
  output logic                           last_o,
  output logic                           moving_o
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit  <= 22'd2097152;
      cfg_q.coef_std     <= 21'd1049;
      cfg_q.coef_fast    <= 21'd52429;
      cfg_q.decay_step   <= 21'd2097;
      cfg_q.moving_floor <= 21'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SPEED_LIMIT:  cfg_q.speed_limit  <= cfg_wdata_i;
        CFG_COEF_STD:     cfg_q.coef_std     <= cfg_wdata_i[COEF_W-1:0];
        CFG_COEF_FAST:    cfg_q.coef_fast    <= cfg_wdata_i[COEF_W-1:0];
        CFG_DECAY_STEP:   cfg_q.decay_step   <= cfg_wdata_i[COEF_W-1:0];
        CFG_MOVING_FLOOR: cfg_q.moving_floor <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // command decode and queue
  tssc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .active_flag_i (active_flag_i),
    .slew_mode_i   (slew_mode_i),
    .value_i       (value_i),
    .lock_dir_i    (lock_dir_i),
    .speed_limit_i (cfg_q.speed_limit),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // execution and sample generation
  tssc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_speed_o (sample_speed_o),
    .last_o         (last_o),
    .moving_o       (moving_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_tape_speed_slew_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tape_speed_slew_controller_core
// drives command words into the tape speed slew controller with random
// gaps, stalls the sample channel at random and checks every sample word
// against a cycle-free predictor of the transport, lock and lowpass
// ----------------------------------------------------------------------------

module tb_tape_speed_slew_controller_core;
  import tssc_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 56;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 2 * (BLOCK + 2) + 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int REPORT_LINES  = 40;

  // codes the package leaves unnamed, plus a spare name for the reserved lock code
  localparam logic [2:0] CFG_SPARE   = 3'd7;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] SLEW_QUICK  = 2'd1;
  localparam logic [1:0] SLEW_SPARE  = 2'd3;
  localparam logic [1:0] LOCK_SPARE  = 2'b10;

  localparam logic signed [SPEED_W-1:0] SPEED_TOP    = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_BOTTOM = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam longint SAT_HI     = 64'sd4194303;
  localparam longint SAT_LO     = -64'sd4194304;
  localparam longint ROUND_HALF = 64'sd524288;

  typedef struct {
    logic signed [SPEED_W-1:0] speed;
    logic                      last;
    logic                      moving;
  } speed_word_t;

  // transport predictor and store of expected sample words
  class speed_scoreboard;
    logic [MAX_W-1:0]   speed_limit;
    logic [COEF_W-1:0]  accel_std;
    logic [COEF_W-1:0]  accel_fast;
    logic [COEF_W-1:0]  release_step;
    logic [COEF_W-1:0]  moving_floor;
    logic               active_on;
    logic               quick_on;
    logic [1:0]         lock_st;
    logic signed [23:0] target_act;
    logic signed [23:0] target_idle;
    logic signed [23:0] nudge_step;
    logic signed [23:0] nudge_acc;
    logic signed [23:0] speed_now;
    speed_word_t        expected_words[$];
    int                 errors;
    int                 checked;

    function new();
      speed_limit  = 22'd2097152;
      accel_std    = 21'd1049;
      accel_fast   = 21'd52429;
      release_step = 21'd2097;
      moving_floor = 21'd1;
      active_on    = 1'b0;
      quick_on     = 1'b0;
      lock_st      = LOCK_NONE;
      target_act   = 24'sd1048576;
      target_idle  = '0;
      nudge_step   = '0;
      nudge_acc    = '0;
      speed_now    = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [MAX_W-1:0] data);
      case (idx)
        CFG_SPEED_LIMIT:  speed_limit  = data;
        CFG_COEF_STD:     accel_std    = data[COEF_W-1:0];
        CFG_COEF_FAST:    accel_fast   = data[COEF_W-1:0];
        CFG_DECAY_STEP:   release_step = data[COEF_W-1:0];
        CFG_MOVING_FLOOR: moving_floor = data[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function longint target_now();
      return active_on ? longint'(target_act) : longint'(target_idle);
    endfunction

    // apply one accepted command word, queue the samples a block produces
    function void note_word(logic [2:0] op, logic flag, logic [1:0] mode,
                            logic signed [SPEED_W-1:0] value, logic [1:0] dir);
      longint      v, mx, lo, hi, tgt, k, rel, na, nd, s, lim;
      speed_word_t w;
      int          i;
      v   = value;
      mx  = speed_limit;
      lo  = -mx;
      hi  = mx;
      case (op)
        OP_SET_ACTIVE: begin
          active_on = flag;
          quick_on  = (mode != SLEW_STANDARD);
          if (mode == SLEW_JUMP) speed_now = 24'(target_now());
          // entering active mode frees a lock that the active speed points away from
          if (active_on) begin
            if (lock_st == LOCK_REV && target_now() > 0) lock_st = LOCK_NONE;
            else if (lock_st == LOCK_FWD && target_now() < 0) lock_st = LOCK_NONE;
          end
        end
        OP_INACTIVE: begin
          if (lock_st == LOCK_REV) begin
            if (v > 0) lock_st = LOCK_NONE;
            else lo = 0;
          end else if (lock_st == LOCK_FWD) begin
            if (v < 0) lock_st = LOCK_NONE;
            else hi = 0;
          end
          target_idle = 24'(clip(v, lo, hi));
        end
        OP_ACTIVE: target_act = 24'(clip(v, -mx, mx));
        OP_NUDGE: begin
          nudge_step = 24'(v);
          if (lock_st == LOCK_REV && v > 0) lock_st = LOCK_NONE;
          else if (lock_st == LOCK_FWD && v < 0) lock_st = LOCK_NONE;
        end
        OP_SET_LOCK: lock_st = (dir == LOCK_REV || dir == LOCK_FWD) ? dir : LOCK_NONE;
        OP_RUN_BLOCK: begin
          tgt = target_now();
          k   = quick_on ? accel_fast : accel_std;
          if (k > longint'(ONE_Q20)) k = longint'(ONE_Q20);
          rel = release_step;
          na  = nudge_acc;
          nd  = nudge_step;
          lim = longint'(NUDGE_LIMIT);
          // nudge accumulator: integrate the delta or decay toward zero
          if (nd != 0) begin
            if (active_on) nudge_acc = 24'(clip(na + nd, -lim, lim));
            else nudge_acc = 24'(clip(na + nd, -mx, mx));
          end else if (na >= 0) begin
            nudge_acc = 24'(clip(na - rel, 0, mx));
          end else begin
            nudge_acc = 24'(clip(na + rel, -mx, 0));
          end
          if (lock_st == LOCK_REV) lo = 0;
          else if (lock_st == LOCK_FWD) hi = 0;
          s = clip(longint'(speed_now) + longint'(nudge_acc), lo, hi);
          // one-pole lowpass, product rounded to nearest with halves upward
          for (i = 0; i < BLOCK; i++) begin
            s = clip(s + ((k * (tgt - s) + ROUND_HALF) >>> 20), SAT_LO, SAT_HI);
            w.speed  = SPEED_W'(s);
            w.last   = (i == BLOCK - 1);
            w.moving = ((s < 0) ? -s : s) > longint'(moving_floor);
            expected_words.push_back(w);
          end
          speed_now = 24'(s);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < REPORT_LINES) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(logic signed [SPEED_W-1:0] speed, logic last, logic moving);
      speed_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected sample word, speed %0d", speed));
        return;
      end
      want = expected_words.pop_front();
      if (speed !== want.speed)
        report($sformatf("word %0d speed %0d, predicted %0d", checked, speed, want.speed));
      if (last !== want.last)
        report($sformatf("word %0d last %b, predicted %b", checked, last, want.last));
      if (moving !== want.moving)
        report($sformatf("word %0d moving %b, predicted %b", checked, moving, want.moving));
      checked++;
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [2:0]                cfg_index_i;
  logic [MAX_W-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [2:0]                op_i;
  logic                      active_flag_i;
  logic [1:0]                slew_mode_i;
  logic signed [SPEED_W-1:0] value_i;
  logic signed [1:0]         lock_dir_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [SPEED_W-1:0] sample_speed_o;
  logic                      last_o;
  logic                      moving_o;

  speed_scoreboard sb;
  bit              quiet_in;
  bit              quiet_out;
  int              stall_left;
  int              cycle_count;

  tape_speed_slew_controller_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .active_flag_i  (active_flag_i),
    .slew_mode_i    (slew_mode_i),
    .value_i        (value_i),
    .lock_dir_i     (lock_dir_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_speed_o (sample_speed_o),
    .last_o         (last_o),
    .moving_o       (moving_o)
  );

  // clock
  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // sample channel: check each word taken, then draw the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(sample_speed_o, last_o, moving_o);
      if ($urandom_range(0, 19) == 0) quiet_out = !quiet_out;
      stall_left = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // one command word; valid stays high on return so back-to-back words don't toggle it
  task automatic send_word(logic [2:0] op, logic flag, logic [1:0] mode,
                           logic signed [SPEED_W-1:0] value, logic [1:0] dir);
    int gap;
    if ($urandom_range(0, 15) == 0) quiet_in = !quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i          <= op;
    active_flag_i <= flag;
    slew_mode_i   <= mode;
    value_i       <= value;
    lock_dir_i    <= dir;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(op, flag, mode, value, dir);
  endtask

  // drop valid and wait until the block has drained
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [MAX_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(logic [MAX_W-1:0] mx, logic [MAX_W-1:0] std_k,
                              logic [MAX_W-1:0] fast_k, logic [MAX_W-1:0] rel,
                              logic [MAX_W-1:0] floor_v, bit poke_spare);
    write_reg(CFG_SPEED_LIMIT, mx);
    write_reg(CFG_COEF_STD, std_k);
    write_reg(CFG_COEF_FAST, fast_k);
    write_reg(CFG_DECAY_STEP, rel);
    write_reg(CFG_MOVING_FLOOR, floor_v);
    if (poke_spare) write_reg(CFG_SPARE, MAX_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // coefficient data, mostly at or below one, bit 21 random
  function automatic logic [MAX_W-1:0] rand_coef();
    logic [COEF_W-1:0] k;
    k = ($urandom_range(0, 7) == 0) ? COEF_W'($urandom)
                                    : COEF_W'($urandom_range(0, ONE_Q20));
    return {1'($urandom_range(0, 1)), k};
  endfunction

  function automatic logic signed [SPEED_W-1:0] rand_speed();
    int r;
    case ($urandom_range(0, 4))
      0: r = int'($urandom);
      1: r = int'($urandom_range(0, 40000)) - 20000;
      2: begin
        case ($urandom_range(0, 4))
          0: r = SPEED_TOP;
          1: r = SPEED_BOTTOM;
          2: r = 0;
          3: r = 1;
          default: r = -1;
        endcase
      end
      3: begin
        r = int'(sb.speed_limit) + int'($urandom_range(0, 200)) - 100;
        if ($urandom_range(0, 1) == 0) r = -r;
      end
      default: r = int'($urandom_range(0, 2097152)) - 1048576;
    endcase
    return SPEED_W'(r);
  endfunction

  // nudge deltas: often zero so the accumulator decays
  function automatic logic signed [SPEED_W-1:0] rand_nudge();
    int r;
    case ($urandom_range(0, 5))
      0, 1:    r = 0;
      2, 3:    r = int'($urandom_range(0, 24000)) - 12000;
      4:       r = int'($urandom_range(0, 1000000)) - 500000;
      default: r = int'($urandom);
    endcase
    return SPEED_W'(r);
  endfunction

  // random command words; spare ops are sent but not counted
  task automatic run_phase(int words);
    int                        done, pick;
    logic [2:0]                op;
    logic signed [SPEED_W-1:0] v;
    done = 0;
    while (done < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) op = OP_RUN_BLOCK;
      else if (pick < 50) op = OP_NUDGE;
      else if (pick < 60) op = OP_ACTIVE;
      else if (pick < 70) op = OP_INACTIVE;
      else if (pick < 83) op = OP_SET_ACTIVE;
      else if (pick < 96) op = OP_SET_LOCK;
      else op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
      v = (op == OP_NUDGE) ? rand_nudge() : rand_speed();
      send_word(op, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), v,
                2'($urandom_range(0, 3)));
      if (op <= OP_RUN_BLOCK) done++;
    end
  endtask

  initial begin
    int p;
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    op_i          = '0;
    active_flag_i = 1'b0;
    slew_mode_i   = '0;
    value_i       = '0;
    lock_dir_i    = '0;
    out_stall_i   = 1'b0;
    quiet_in      = 1'b0;
    quiet_out     = 1'b0;
    stall_left    = 0;
    cycle_count   = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset settings
    send_word(OP_RUN_BLOCK, 1'b0, SLEW_STANDARD, '0, LOCK_NONE);
    send_word(OP_ACTIVE, 1'b0, SLEW_STANDARD, SPEED_BOTTOM, LOCK_NONE);
    send_word(OP_SET_ACTIVE, 1'b1, SLEW_JUMP, '0, LOCK_NONE);
    send_word(OP_SET_LOCK, 1'b0, SLEW_STANDARD, '0, LOCK_FWD);
    send_word(OP_RUN_BLOCK, 1'b0, SLEW_STANDARD, '0, LOCK_NONE);
    // negative active speed frees the forward lock
    send_word(OP_SET_ACTIVE, 1'b1, SLEW_QUICK, '0, LOCK_NONE);
    send_word(OP_NUDGE, 1'b0, SLEW_STANDARD, SPEED_TOP, LOCK_NONE);
    send_word(OP_RUN_BLOCK, 1'b0, SLEW_STANDARD, '0, LOCK_NONE);
    send_word(OP_NUDGE, 1'b0, SLEW_STANDARD, '0, LOCK_NONE);
    send_word(OP_RUN_BLOCK, 1'b0, SLEW_STANDARD, '0, LOCK_NONE);
    // inactive speed against a reverse lock is held at zero
    send_word(OP_SET_LOCK, 1'b0, SLEW_STANDARD, '0, LOCK_REV);
    send_word(OP_INACTIVE, 1'b0, SLEW_STANDARD, -23'sd1000, LOCK_NONE);
    send_word(OP_SET_LOCK, 1'b0, SLEW_STANDARD, '0, LOCK_SPARE);
    send_word(OP_SET_LOCK, 1'b0, SLEW_STANDARD, '0, LOCK_FWD);
    send_word(OP_INACTIVE, 1'b0, SLEW_STANDARD, SPEED_TOP, LOCK_NONE);
    send_word(OP_INACTIVE, 1'b0, SLEW_STANDARD, SPEED_BOTTOM, LOCK_NONE);
    send_word(OP_SET_ACTIVE, 1'b0, SLEW_SPARE, '0, LOCK_NONE);
    send_word(OP_NUDGE, 1'b0, SLEW_STANDARD, SPEED_BOTTOM, LOCK_NONE);
    send_word(OP_RUN_BLOCK, 1'b0, SLEW_STANDARD, '0, LOCK_NONE);
    send_word(OP_SPARE_LO, 1'b1, SLEW_JUMP, SPEED_TOP, LOCK_REV);
    send_word(OP_SPARE_HI, 1'b1, SLEW_QUICK, SPEED_BOTTOM, LOCK_FWD);
    send_word(OP_SET_LOCK, 1'b0, SLEW_STANDARD, '0, LOCK_REV);
    send_word(OP_NUDGE, 1'b0, SLEW_STANDARD, 23'sd5, LOCK_NONE);
    send_word(OP_SET_ACTIVE, 1'b0, SLEW_STANDARD, '0, LOCK_NONE);
    send_word(OP_RUN_BLOCK, 1'b0, SLEW_STANDARD, '0, LOCK_NONE);
    settle();

    // random phases, each under its own register settings
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(22'h3FFFFF, MAX_W'(ONE_Q20), 22'h1FFFFF, MAX_W'(ONE_Q20),
                        MAX_W'(ONE_Q20), 1'b1);
        1: program_regs('0, '0, '0, '0, '0, 1'b0);
        2: program_regs(22'd2097152, 22'h1FFFFF, 22'd1048577, 22'd1, 22'h1FFFFF, 1'b0);
        3: program_regs(22'd2097152, 22'd1049, 22'd52429, 22'd2097, 22'd1, 1'b0);
        default: program_regs(MAX_W'($urandom), rand_coef(), rand_coef(), rand_coef(),
                              {1'($urandom_range(0, 1)), 21'($urandom_range(0, 5000))},
                              1'b0);
      endcase
      run_phase(PHASE_WORDS);
      settle();
    end

    if (sb.errors == 0 && sb.expected_words.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
